// ===== hw/rtl/vtp_pkg.sv =====
// shared types and constants for the vertex transform and projection block
package vtp_pkg;

    // widths of the datapath
    localparam int COORD_W = 16;                // input coordinates and coefficients
    localparam int ROT_W   = 25;                // rotated and translated coordinate
    localparam int PROD_W  = 36;                // registered product and accumulator
    localparam int DIV_DW  = 35;                // divider dividend and quotient
    localparam int DIV_VW  = 25;                // divider divisor
    localparam int FOCAL_W = 10;
    localparam int HALF_W  = 12;
    localparam int SCR_W   = 16;

    localparam int CAM_DIV = 40;                // camera distance is focal / 40

    // focal / 40 as a right shift by 3 and a multiply by 1/5
    // ceil(2^22 / 5) is exact for every dividend below 2^22
    localparam int          CAM_PRE_SH   = 3;
    localparam logic [19:0] CAM_RECIP    = 20'd838861;
    localparam int          CAM_RECIP_SH = 22;

    localparam int MAT_DEPTH = 9;
    localparam logic [3:0] MAT_LAST = 4'd8;

    // request modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_VERTEX = 1'b1;

    // register indexes on the apb port
    localparam logic [1:0] REG_FOCAL       = 2'd0;
    localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HALF_HEIGHT = 2'd2;

    localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 10'd400;
    localparam logic [HALF_W-1:0]  HALF_W_RESET = 12'd500;
    localparam logic [HALF_W-1:0]  HALF_H_RESET = 12'd375;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/vtp_if.sv =====
// request and result channel interfaces
interface vtp_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [3:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic signed [15:0] shift_z;

    modport source (
        output valid, mode, coef_index, coef_value,
        output vert_x, vert_y, vert_z, shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, mode, coef_index, coef_value,
        input  vert_x, vert_y, vert_z, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

interface vtp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               depth_invalid;
    logic               saturated;

    modport source (
        output valid, screen_x, screen_y, depth_invalid, saturated,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, depth_invalid, saturated,
        output ready
    );
endinterface

// ===== hw/rtl/vtp_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module vtp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vtp_pkg::t_div_req i_req,
    output vtp_pkg::t_div_rsp o_rsp
);
    import vtp_pkg::*;

    localparam int CNT_W = $clog2(DIV_DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_den;
    logic [DIV_DW-1:0] r_quo;

    logic [DIV_VW:0] rem_sh;
    logic [DIV_VW:0] diff;
    logic            fits;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_DW-1]};
        diff   = rem_sh - {1'b0, r_den};
        fits   = !diff[DIV_VW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_W'(DIV_DW - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_DW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], fits};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hw/rtl/vertex_transform_project_top.sv =====
// vertex rotation, translation and perspective projection with a shared multiplier and divider
// a coefficient load request is written on acceptance and leaves ready high; a vertex request
// runs the multiply-accumulate over the matrix rows, the depth check, then two passes of the
// shared restoring divider (x, y), skipped when the point is behind the camera; ready rises
// with its result, so one vertex ends before the next is taken; a held result stalls the input
// synchronous active-low reset restores the identity matrix and the register defaults
module vertex_transform_project_top #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int COEF_FRAC_BITS  = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vtp_in_if.sink      i_in,
    vtp_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vtp_pkg::*;

    localparam int SCALED_W = FOCAL_W + COORD_FRAC_BITS - CAM_PRE_SH;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_MAC_END, S_DIST, S_CHECK, S_NX, S_DX, S_NY, S_DY, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [FOCAL_W-1:0] r_focal;
    logic [HALF_W-1:0]  r_half_w;
    logic [HALF_W-1:0]  r_half_h;
    logic               cfg_wr;

    // matrix and request operands
    logic signed [COORD_W-1:0] r_mat [MAT_DEPTH];
    logic signed [COORD_W-1:0] r_vert [3];
    logic signed [COORD_W-1:0] r_shift [3];

    // mac sequencing
    logic [1:0]               r_row;
    logic [1:0]               r_col;
    logic                     r_pvalid;
    logic                     r_plast;
    logic [1:0]               r_prow;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [ROT_W-1:0]  r_rot [3];
    logic signed [ROT_W-1:0]  r_den;
    logic                     r_neg;
    logic signed [DIV_DW:0]   r_px;
    logic                     r_inv;
    logic signed [SCR_W-1:0]  r_clamp_x;
    logic                     r_clamp_sat;

    // result register
    logic                     r_out_valid;
    logic signed [SCR_W-1:0]  r_sx;
    logic signed [SCR_W-1:0]  r_sy;
    logic                     r_dinv;
    logic                     r_sat;

    logic [3:0]               mat_idx;
    logic signed [ROT_W-1:0]  mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [ROT_W+COORD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [PROD_W-1:0] acc_shr;
    logic signed [ROT_W-1:0]  row_val;
    logic [DIV_DW-1:0]        prod_mag;
    logic signed [DIV_DW:0]   q_signed;
    logic signed [DIV_DW+1:0] sx_full;
    logic signed [DIV_DW+1:0] sy_full;
    logic [SCALED_W-1:0]      cam_scaled;
    logic [SCALED_W+$bits(CAM_RECIP)-1:0] cam_prod;
    logic signed [ROT_W-1:0]  cam_dist;
    logic                     out_free;
    logic                     in_acc;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    vtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // apb side
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_FOCAL:       prdata = {{(32-FOCAL_W){1'b0}}, r_focal};
            REG_HALF_WIDTH:  prdata = {{(32-HALF_W){1'b0}}, r_half_w};
            REG_HALF_HEIGHT: prdata = {{(32-HALF_W){1'b0}}, r_half_h};
            default:         prdata = '0;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // camera distance, (focal << frac) / 40 by reciprocal multiply
    always_comb begin
        cam_scaled = {r_focal, {(COORD_FRAC_BITS-CAM_PRE_SH){1'b0}}};
        cam_prod   = cam_scaled * CAM_RECIP;
        cam_dist   = $signed(ROT_W'(cam_prod[SCALED_W+$bits(CAM_RECIP)-1:CAM_RECIP_SH]));
    end

    // shared multiplier operand select
    always_comb begin
        mat_idx = {1'b0, r_row, 1'b0} + {2'b00, r_row} + {2'b00, r_col};
        case (r_state)
            S_CHECK: begin
                mul_a = r_rot[0];
                mul_b = COORD_W'($signed({1'b0, r_focal}));
            end
            S_DX: begin
                mul_a = r_rot[1];
                mul_b = COORD_W'($signed({1'b0, r_focal}));
            end
            default: begin
                case (r_col)
                    2'd0:    mul_a = {{(ROT_W-COORD_W){r_vert[0][COORD_W-1]}}, r_vert[0]};
                    2'd1:    mul_a = {{(ROT_W-COORD_W){r_vert[1][COORD_W-1]}}, r_vert[1]};
                    default: mul_a = {{(ROT_W-COORD_W){r_vert[2][COORD_W-1]}}, r_vert[2]};
                endcase
                mul_b = r_mat[mat_idx];
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // accumulate and row finish; arithmetic shift floors
    always_comb begin
        acc_sum = r_acc + r_prod;
        acc_shr = acc_sum >>> COEF_FRAC_BITS;
        row_val = acc_shr[ROT_W-1:0]
                + {{(ROT_W-COORD_W){r_shift[r_prow][COORD_W-1]}}, r_shift[r_prow]};
    end

    // divider request
    always_comb begin
        prod_mag = r_prod[PROD_W-1] ? DIV_DW'(-r_prod) : DIV_DW'(r_prod);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            S_NX, S_NY: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_mag;
                div_req.divisor  = DIV_VW'(r_den);
            end
            default: ;
        endcase
        q_signed = r_neg ? -$signed({1'b0, div_rsp.quotient})
                         :  $signed({1'b0, div_rsp.quotient});
        sx_full  = {r_px[DIV_DW], r_px} + $signed({{(DIV_DW+2-HALF_W){1'b0}}, r_half_w});
        sy_full  = $signed({{(DIV_DW+2-HALF_W){1'b0}}, r_half_h}) - {r_px[DIV_DW], r_px};
    end

    // config and matrix storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= FOCAL_RESET;
            r_half_w <= HALF_W_RESET;
            r_half_h <= HALF_H_RESET;
            for (int i = 0; i < MAT_DEPTH; i++) begin
                r_mat[i] <= (i % 4 == 0) ? COORD_W'(1 << COEF_FRAC_BITS) : '0;
            end
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_FOCAL:       r_focal  <= pwdata[FOCAL_W-1:0];
                    REG_HALF_WIDTH:  r_half_w <= pwdata[HALF_W-1:0];
                    REG_HALF_HEIGHT: r_half_h <= pwdata[HALF_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc && i_in.mode == MODE_LOAD && i_in.coef_index <= MAT_LAST) begin
                r_mat[i_in.coef_index] <= i_in.coef_value;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pvalid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_pvalid <= (r_state == S_MAC);
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.mode == MODE_VERTEX) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_col == 2'd2) begin
                        r_col <= '0;
                        if (r_row == 2'd2) begin
                            r_row   <= '0;
                            r_state <= S_MAC_END;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_MAC_END: r_state <= S_DIST;
                S_DIST:    r_state <= S_CHECK;
                S_CHECK:   r_state <= (r_den <= 0) ? S_FIN : S_NX;
                S_NX:      r_state <= S_DX;
                S_DX: begin
                    if (div_rsp.done) begin
                        r_state <= S_NY;
                    end
                end
                S_NY:    r_state <= S_DY;
                S_DY: begin
                    if (div_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.mode == MODE_VERTEX) begin
            r_vert[0]  <= i_in.vert_x;
            r_vert[1]  <= i_in.vert_y;
            r_vert[2]  <= i_in.vert_z;
            r_shift[0] <= i_in.shift_x;
            r_shift[1] <= i_in.shift_y;
            r_shift[2] <= i_in.shift_z;
            r_acc      <= '0;
        end
        if (r_state == S_MAC || r_state == S_CHECK || (r_state == S_DX && div_rsp.done)) begin
            r_prod <= mul_p[PROD_W-1:0];
        end
        if (r_state == S_MAC) begin
            r_plast <= (r_col == 2'd2);
            r_prow  <= r_row;
        end
        if (r_pvalid) begin
            if (r_plast) begin
                r_rot[r_prow] <= row_val;
                r_acc         <= '0;
            end else begin
                r_acc <= acc_sum;
            end
        end
        if (r_state == S_DIST) begin
            r_den <= r_rot[2] + cam_dist;
        end
        if (r_state == S_CHECK) begin
            r_inv <= (r_den <= 0);
        end
        if (r_state == S_NX || r_state == S_NY) begin
            r_neg <= r_prod[PROD_W-1];
        end
        if (r_state == S_DX && div_rsp.done) begin
            r_px <= q_signed;
        end
        if (r_state == S_DY && div_rsp.done) begin
            r_px <= q_signed;
            // x clamp held apart so a waiting result stays intact
            r_clamp_x   <= (sx_full > 32767)  ? 16'sh7fff :
                           (sx_full < -32768) ? 16'sh8000 : sx_full[SCR_W-1:0];
            r_clamp_sat <= (sx_full > 32767) || (sx_full < -32768);
        end
        if (r_state == S_FIN && out_free) begin
            r_dinv <= r_inv;
            if (r_inv) begin
                r_sx  <= '0;
                r_sy  <= '0;
                r_sat <= 1'b0;
            end else begin
                r_sx  <= r_clamp_x;
                r_sy  <= (sy_full > 32767)  ? 16'sh7fff :
                         (sy_full < -32768) ? 16'sh8000 : sy_full[SCR_W-1:0];
                r_sat <= r_clamp_sat || (sy_full > 32767) || (sy_full < -32768);
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.screen_x      = r_sx;
    assign o_out.screen_y      = r_sy;
    assign o_out.depth_invalid = r_dinv;
    assign o_out.saturated     = r_sat;

`ifndef ASSERT_OFF
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DX || r_state == S_DY))
        else $error("divider finished outside a wait state");

    a_pvalid_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvalid |-> (r_state == S_MAC || r_state == S_MAC_END))
        else $error("product pending outside accumulation");

    a_vertex_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == MODE_VERTEX) |=> !i_in.ready)
        else $error("ready right after a vertex request");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.depth_invalid) |->
            (o_out.screen_x == 0 && o_out.screen_y == 0 && !o_out.saturated))
        else $error("invalid depth result with nonzero fields");
`endif

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the vertex transform and projection block
module tb;
    import vtp_pkg::*;

    localparam int COORD_FRAC = 8;
    localparam int COEF_FRAC  = 14;
    localparam int REG_UNUSED = 3;          // no register lives here
    localparam int DRAIN_TAIL = 200;        // idle wait, longer than a whole vertex takes
    localparam int CYCLE_LIMIT = 600000;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 72;

    typedef struct packed {
        logic               mode;
        logic [3:0]         coef_index;
        logic signed [15:0] coef_value;
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic signed [15:0] vert_z;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
        logic signed [15:0] shift_z;
    } t_vtx_req;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               depth_invalid;
        logic               saturated;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vtp_in_if  in_ch ();
    vtp_out_if out_ch ();

    vertex_transform_project_top #(
        .COORD_FRAC_BITS(COORD_FRAC),
        .COEF_FRAC_BITS (COEF_FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // predictor state
    logic signed [15:0]  coef_store [MAT_DEPTH];
    logic [FOCAL_W-1:0]  focal_cfg;
    logic [HALF_W-1:0]   half_w_cfg;
    logic [HALF_W-1:0]   half_h_cfg;
    t_point              pending_points [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_on = 1'b0;
    bit  rx_idle_on = 1'b0;
    bit  result_taken = 1'b0;
    int  hold_request = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic t_point project_point(input t_vtx_req rq);
        longint vin [3];
        longint sh [3];
        longint rot [3];
        longint acc, cam_dist, depth, px, py, sx, sy;
        t_point res;
        vin[0] = longint'($signed(rq.vert_x));
        vin[1] = longint'($signed(rq.vert_y));
        vin[2] = longint'($signed(rq.vert_z));
        sh[0]  = longint'($signed(rq.shift_x));
        sh[1]  = longint'($signed(rq.shift_y));
        sh[2]  = longint'($signed(rq.shift_z));
        for (int row = 0; row < 3; row++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += longint'(coef_store[row*3 + j]) * vin[j];
            rot[row] = (acc >>> COEF_FRAC) + sh[row];
        end
        res = '0;
        cam_dist = (longint'(focal_cfg) * (longint'(1) << COORD_FRAC)) / CAM_DIV;
        depth = rot[2] + cam_dist;
        if (depth <= 0) begin
            res.depth_invalid = 1'b1;
            return res;
        end
        px = (rot[0] * longint'(focal_cfg)) / depth;
        py = (rot[1] * longint'(focal_cfg)) / depth;
        sx = px + longint'(half_w_cfg);
        sy = longint'(half_h_cfg) - py;
        if (sx > 32767) begin
            sx = 32767;
            res.saturated = 1'b1;
        end else if (sx < -32768) begin
            sx = -32768;
            res.saturated = 1'b1;
        end
        if (sy > 32767) begin
            sy = 32767;
            res.saturated = 1'b1;
        end else if (sy < -32768) begin
            sy = -32768;
            res.saturated = 1'b1;
        end
        res.screen_x = 16'(sx);
        res.screen_y = 16'(sy);
        return res;
    endfunction

    function automatic void apply_request(input t_vtx_req rq);
        if (rq.mode == MODE_LOAD) begin
            if (rq.coef_index <= MAT_LAST)
                coef_store[rq.coef_index] = rq.coef_value;
        end else begin
            pending_points.push_back(project_point(rq));
        end
    endfunction

    function automatic t_vtx_req load_req(input int idx, input logic [15:0] value);
        t_vtx_req rq;
        rq = t_vtx_req'({$urandom, $urandom, $urandom, $urandom});
        rq.mode = MODE_LOAD;
        rq.coef_index = 4'(idx);
        rq.coef_value = value;
        return rq;
    endfunction

    function automatic t_vtx_req vertex_req(input logic [15:0] vx, vy, vz, tx, ty, tz);
        t_vtx_req rq;
        rq = t_vtx_req'({$urandom, $urandom, $urandom, $urandom});
        rq.mode = MODE_VERTEX;
        rq.vert_x = vx;
        rq.vert_y = vy;
        rq.vert_z = vz;
        rq.shift_x = tx;
        rq.shift_y = ty;
        rq.shift_z = tz;
        return rq;
    endfunction

    function automatic logic [15:0] small_word(input int span);
        return 16'($urandom_range(0, 2*span)) - 16'(span);
    endfunction

    function automatic t_vtx_req random_item();
        t_vtx_req rq;
        longint cam_dist;
        rq = t_vtx_req'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 99) < 30) begin
            rq.mode = MODE_LOAD;
            if ($urandom_range(0, 9) == 0)
                rq.coef_index = 4'($urandom_range(9, 15));
            else
                rq.coef_index = 4'($urandom_range(0, 8));
            if ($urandom_range(0, 1) == 0)
                rq.coef_value = small_word(16384);
            return rq;
        end
        rq.mode = MODE_VERTEX;
        case ($urandom_range(0, 3))
            0, 1: begin
                rq.vert_x = small_word(4096);
                rq.vert_y = small_word(4096);
                rq.vert_z = small_word(4096);
                rq.shift_x = small_word(4096);
                rq.shift_y = small_word(4096);
                rq.shift_z = 16'($urandom_range(0, 8192));
            end
            2: begin
                // full-range words already in place
            end
            default: begin
                // hover around the camera plane
                cam_dist = (longint'(focal_cfg) * (longint'(1) << COORD_FRAC)) / CAM_DIV;
                rq.vert_x = small_word(64);
                rq.vert_y = small_word(64);
                rq.vert_z = small_word(64);
                rq.shift_z = 16'(-cam_dist) + small_word(32);
            end
        endcase
        return rq;
    endfunction

    task automatic send_item(input t_vtx_req rq);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.mode       <= rq.mode;
        in_ch.coef_index <= rq.coef_index;
        in_ch.coef_value <= rq.coef_value;
        in_ch.vert_x     <= rq.vert_x;
        in_ch.vert_y     <= rq.vert_y;
        in_ch.vert_z     <= rq.vert_z;
        in_ch.shift_x    <= rq.shift_x;
        in_ch.shift_y    <= rq.shift_y;
        in_ch.shift_z    <= rq.shift_z;
        in_ch.valid      <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        apply_request(rq);
    endtask

    task automatic tx_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_results();
        tx_idle();
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    // block is idle afterwards, loads included
    task automatic wait_drained();
        wait_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic apb_access(input int reg_idx, input bit is_write, input logic [31:0] value,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= 4'(reg_idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (is_write) begin
            if (reg_idx == int'(REG_FOCAL))
                focal_cfg = value[FOCAL_W-1:0];
            else if (reg_idx == int'(REG_HALF_WIDTH))
                half_w_cfg = value[HALF_W-1:0];
            else if (reg_idx == int'(REG_HALF_HEIGHT))
                half_h_cfg = value[HALF_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        logic [31:0] rdata;
        apb_access(int'(REG_FOCAL), 1'b0, '0, rdata);
        if (rdata[FOCAL_W-1:0] !== focal_cfg)
            report_mismatch("focal_length readback", rdata, focal_cfg);
        apb_access(int'(REG_HALF_WIDTH), 1'b0, '0, rdata);
        if (rdata[HALF_W-1:0] !== half_w_cfg)
            report_mismatch("half_width readback", rdata, half_w_cfg);
        apb_access(int'(REG_HALF_HEIGHT), 1'b0, '0, rdata);
        if (rdata[HALF_W-1:0] !== half_h_cfg)
            report_mismatch("half_height readback", rdata, half_h_cfg);
    endtask

    task automatic set_config(input int focal, input int half_w, input int half_h);
        logic [31:0] rdata;
        apb_access(int'(REG_FOCAL), 1'b1, 32'(focal), rdata);
        apb_access(int'(REG_HALF_WIDTH), 1'b1, 32'(half_w), rdata);
        apb_access(int'(REG_HALF_HEIGHT), 1'b1, 32'(half_h), rdata);
        check_registers();
    endtask

    // result side: ready with random gaps and an optional long hold
    initial begin
        int hold_left;
        int rx_gap;
        hold_left = 0;
        rx_gap = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (result_taken) begin
                result_taken = 1'b0;
                rx_gap = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_taken = 1'b1;
            if (pending_points.size() == 0) begin
                report_mismatch("result with nothing pending, screen_x", out_ch.screen_x, 0);
            end else begin
                want = pending_points.pop_front();
                if (out_ch.screen_x !== want.screen_x)
                    report_mismatch("screen_x", out_ch.screen_x, want.screen_x);
                if (out_ch.screen_y !== want.screen_y)
                    report_mismatch("screen_y", out_ch.screen_y, want.screen_y);
                if (out_ch.depth_invalid !== want.depth_invalid)
                    report_mismatch("depth_invalid", out_ch.depth_invalid, want.depth_invalid);
                if (out_ch.saturated !== want.saturated)
                    report_mismatch("saturated", out_ch.saturated, want.saturated);
            end
        end
    end

    task automatic test_reset_defaults();
        check_registers();
        send_item(vertex_req(16'sd256, -16'sd512, 16'sd1024, 16'sd0, 16'sd0, 16'sd0));
        wait_drained();
    endtask

    task automatic test_coef_loads();
        // out-of-range positions must leave the matrix alone
        send_item(load_req(9, 16'h7fff));
        send_item(load_req(15, 16'h8000));
        send_item(vertex_req(16'sd300, 16'sd200, -16'sd100, 16'sd0, 16'sd0, 16'sd512));
        send_item(load_req(0, 16'h7fff));
        send_item(load_req(1, 16'h8000));
        send_item(load_req(2, 16'h2000));
        send_item(load_req(3, 16'hc000));
        send_item(load_req(4, 16'h7fff));
        send_item(load_req(5, 16'h8000));
        send_item(load_req(6, 16'h8000));
        send_item(load_req(7, 16'h0001));
        send_item(load_req(8, 16'h7fff));
        send_item(vertex_req(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff));
        send_item(vertex_req(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
        wait_drained();
    endtask

    task automatic test_depth_invalid();
        // zero vertex: the point is the translation alone, camera distance 2560
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd9, -16'sd2560));
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd9, 16'h8000));
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, 16'sd3, -16'sd2, -16'sd2559));
        wait_drained();
    endtask

    task automatic test_saturation();
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd100, -16'sd2559));
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, -16'sd100, -16'sd100, -16'sd2559));
        wait_drained();
    endtask

    task automatic test_config_extremes();
        logic [31:0] rdata;
        set_config(0, 0, 4095);
        // zero focal length: divisor is rz alone
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd0));
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd1));
        wait_drained();
        set_config(1023, 4095, 0);
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, 16'sd1000, -16'sd1000, 16'sd0));
        wait_drained();
        apb_access(REG_UNUSED, 1'b1, 32'hffff_ffff, rdata);
        check_registers();
        set_config(50, 2048, 1024);
        send_item(vertex_req(16'sd0, 16'sd0, 16'sd0, -16'sd1000, 16'sd1000, -16'sd319));
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_config(int'(FOCAL_RESET), int'(HALF_W_RESET), int'(HALF_H_RESET));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        @(posedge i_clk);
        hold_request = RX_HOLD_CYCLES;
        for (int k = 0; k < 10; k++)
            send_item(random_item());
        wait_drained();
    endtask

    task automatic test_random();
        int focal, half_w, half_h;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: focal = (phase % 2 == 0) ? 50 : 900;
                1: focal = (phase % 2 == 0) ? 0 : 1023;
                default: focal = $urandom_range(0, 1023);
            endcase
            half_w = ($urandom_range(0, 3) == 0) ? (phase % 2) * 4095 : $urandom_range(0, 4095);
            half_h = ($urandom_range(0, 3) == 0) ? (phase % 2) * 4095 : $urandom_range(0, 4095);
            set_config(focal, half_w, half_h);
            tx_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_item(random_item());
                if (k == PHASE_ITEMS / 2)
                    wait_results();
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_LOAD;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.vert_x = '0;
        in_ch.vert_y = '0;
        in_ch.vert_z = '0;
        in_ch.shift_x = '0;
        in_ch.shift_y = '0;
        in_ch.shift_z = '0;
        for (int i = 0; i < MAT_DEPTH; i++)
            coef_store[i] = (i % 4 == 0) ? 16'(1 << COEF_FRAC) : 16'sd0;
        focal_cfg = FOCAL_RESET;
        half_w_cfg = HALF_W_RESET;
        half_h_cfg = HALF_H_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_defaults();
        test_coef_loads();
        test_depth_invalid();
        test_saturation();
        test_config_extremes();
        test_backpressure();
        test_random();
        wait_drained();

        if (pending_points.size() != 0)
            report_mismatch("requests left without a result", pending_points.size(), 0);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
